// File: hw/rtl/ism_pkg.sv
// Shared constants, types and command codes of the itemset subset matcher.
package ism_pkg;

	localparam int ITEM_COUNT = 256;
	localparam int PATTERNS   = 64;

	localparam int WORD_BITS  = 64;
	localparam int WORDS      = (ITEM_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_BITS   = WORDS * WORD_BITS;
	localparam int ITEM_IDX_W = $clog2(ROW_BITS);
	localparam int ID_CMP_W   = 11;

	localparam int PAT_IDX_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int PAT_CNT_W  = $clog2(PATTERNS + 1);

	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 6;
	localparam int ID_W       = 9;
	localparam int CFG_W      = 7;
	localparam int ROW_W      = 24;
	localparam int MATCH_W    = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FUNC_W-1:0] FUNC_PAT_ADD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PAT_CLR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TXN     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_ROW_RST = 2'd3;

	typedef logic [1:0] op_t;

	localparam op_t OP_PAT_ADD = 2'd0;
	localparam op_t OP_PAT_CLR = 2'd1;
	localparam op_t OP_TXN     = 2'd2;
	localparam op_t OP_ROW_RST = 2'd3;

	typedef struct packed {
		op_t                   op;
		logic [PAT_IDX_W-1:0]  slot;
		logic [ITEM_IDX_W-1:0] id;
		logic                  set_en;
		logic                  last;
	} cmd_t;

endpackage

// File: hw/rtl/itemset_subset_matcher.sv
// Top level of the itemset subset matcher with its configuration register.
//
// Input words are accepted in every cycle while the four-word command queue has
// room; words that change nothing are dropped at the front end. In the back end a
// pattern add reads and then writes the pattern RAM; a pattern clear, row restart
// or transaction item is applied from the idle state; and a transaction's last item
// starts a scan of min(pattern_count, 64) pattern rows (no scan when the count is
// zero), which reads one pattern row per cycle through the single read port of the
// pattern RAM, except while a match waits on the output register. Pattern rows
// carry valid bits that reset and the clear command drop at once, so no clearing
// pass runs. Matches leave in rising pattern order through an output register,
// the last one of a transaction flagged.
module itemset_subset_matcher
	import ism_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [SLOT_W-1:0]  pattern_slot,
	input  logic [ID_W-1:0]    item_id,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   row_index,
	output logic [MATCH_W-1:0] matched_pattern,
	output logic               last_match
);

	logic [CFG_W-1:0] pattern_count_q;
	logic             q_full;
	logic             q_empty;
	logic             push;
	logic             pop;
	cmd_t             push_cmd;
	cmd_t             head_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(pattern_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			pattern_count_q <= pwdata[CFG_W-1:0];
		end
	end

	ism_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.pattern_slot(pattern_slot),
		.item_id     (item_id),
		.last_item   (last_item),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	ism_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head_cmd(head_cmd),
		.empty   (q_empty)
	);

	ism_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pattern_count  (pattern_count_q),
		.q_empty        (q_empty),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row_index      (row_index),
		.matched_pattern(matched_pattern),
		.last_match     (last_match)
	);

endmodule

// File: hw/rtl/ism_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ism_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/ism_queue.sv
// Short command queue between the front end and the back end.
module ism_queue
	import ism_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty
);

	cmd_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/ism_front.sv
// Front end: accepts input words, decodes them and drops those without effect.
module ism_front
	import ism_pkg::*;
(
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [SLOT_W-1:0] pattern_slot,
	input  logic [ID_W-1:0]   item_id,
	input  logic              last_item,
	input  logic              q_full,
	output logic              push,
	output cmd_t              push_cmd
);

	logic [ID_CMP_W-1:0] id_w;
	logic                id_ok;
	logic                slot_ok;
	logic                keep;

	always_comb begin
		id_w    = ID_CMP_W'(item_id[ID_W-2:0]);
		id_ok   = !item_id[ID_W-1] && (id_w < ID_CMP_W'(ITEM_COUNT));
		slot_ok = ({1'b0, pattern_slot} < (SLOT_W + 1)'(PATTERNS));

		push_cmd.op     = OP_TXN;
		push_cmd.slot   = PAT_IDX_W'(pattern_slot);
		push_cmd.id     = id_w[ITEM_IDX_W-1:0];
		push_cmd.set_en = 1'b0;
		push_cmd.last   = 1'b0;
		keep            = 1'b0;

		unique case (func)
			FUNC_PAT_ADD: begin
				push_cmd.op     = OP_PAT_ADD;
				push_cmd.set_en = 1'b1;
				keep            = id_ok && slot_ok;
			end
			FUNC_PAT_CLR: begin
				push_cmd.op = OP_PAT_CLR;
				keep        = 1'b1;
			end
			FUNC_TXN: begin
				push_cmd.op     = OP_TXN;
				push_cmd.set_en = id_ok && (id_w != '0);
				push_cmd.last   = last_item;
				keep            = push_cmd.set_en || last_item;
			end
			FUNC_ROW_RST: begin
				push_cmd.op = OP_ROW_RST;
				keep        = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && keep;

endmodule

// File: hw/rtl/ism_back.sv
// Back end: pattern store updates, transaction collection and the subset scan.
module ism_back
	import ism_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CFG_W-1:0]   pattern_count,
	input  logic               q_empty,
	input  cmd_t               head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   row_index,
	output logic [MATCH_W-1:0] matched_pattern,
	output logic               last_match
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ADD_WR = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;

	logic [1:0]            state_q;
	logic [PATTERNS-1:0]   pat_valid_q;
	logic [ROW_BITS-1:0]   txn_q;
	logic [ROW_W-1:0]      row_q;
	logic [PAT_IDX_W-1:0]  add_slot_q;
	logic [ITEM_IDX_W-1:0] add_id_q;
	logic [PAT_CNT_W-1:0]  rd_ptr_q;
	logic                  rd_vld_s1;
	logic [PAT_IDX_W-1:0]  rd_idx_s1;
	logic                  hold_vld_q;
	logic [PAT_IDX_W-1:0]  hold_idx_q;
	logic                  out_vld_q;
	logic [ROW_W-1:0]      out_row_q;
	logic [MATCH_W-1:0]    out_pat_q;
	logic                  out_last_q;

	logic [PAT_CNT_W-1:0]  n_c;
	logic [ROW_BITS-1:0]   rdata;
	logic [ROW_BITS-1:0]   wdata_c;
	logic                  re_c;
	logic [PAT_IDX_W-1:0]  raddr_c;
	logic                  we_c;
	logic                  match_c;
	logic                  emit_mid_c;
	logic                  out_free_c;
	logic                  adv_c;
	logic                  done_c;
	logic                  rd_issue_c;
	logic                  finish_c;
	logic                  load_c;

	ism_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(PATTERNS)
	) u_pat_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(add_slot_q),
		.wdata(wdata_c),
		.re   (re_c),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	always_comb begin
		n_c = (pattern_count > CFG_W'(PATTERNS)) ? PAT_CNT_W'(PATTERNS)
			: PAT_CNT_W'(pattern_count);

		pop = (state_q == S_IDLE) && !q_empty;

		we_c    = (state_q == S_ADD_WR);
		wdata_c = (pat_valid_q[add_slot_q] ? rdata : '0)
			| (ROW_BITS'(1) << add_id_q);

		match_c    = !pat_valid_q[rd_idx_s1] || ((rdata & ~txn_q) == '0);
		emit_mid_c = rd_vld_s1 && match_c && hold_vld_q;
		out_free_c = !out_vld_q || out_ready;
		adv_c      = (state_q == S_SCAN) && (!emit_mid_c || out_free_c);
		done_c     = (state_q == S_SCAN) && !rd_vld_s1 && (rd_ptr_q == n_c);
		rd_issue_c = adv_c && (rd_ptr_q != n_c);
		finish_c   = done_c && (!hold_vld_q || out_free_c);
		load_c     = (adv_c && emit_mid_c) || (finish_c && hold_vld_q);

		re_c    = (pop && (head_cmd.op == OP_PAT_ADD)) || rd_issue_c;
		raddr_c = (state_q == S_SCAN) ? rd_ptr_q[PAT_IDX_W-1:0] : head_cmd.slot;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			add_slot_q <= head_cmd.slot;
			add_id_q   <= head_cmd.id;
		end
		if (rd_issue_c) begin
			rd_idx_s1 <= rd_ptr_q[PAT_IDX_W-1:0];
		end
		if (adv_c && rd_vld_s1 && match_c) begin
			hold_idx_q <= rd_idx_s1;
		end
		if (load_c) begin
			out_row_q  <= row_q;
			out_pat_q  <= MATCH_W'(hold_idx_q);
			out_last_q <= finish_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pat_valid_q <= '0;
			txn_q       <= '0;
			row_q       <= '0;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			hold_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (load_c) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (head_cmd.op)
							OP_PAT_ADD: begin
								state_q <= S_ADD_WR;
							end
							OP_PAT_CLR: begin
								pat_valid_q <= '0;
							end
							OP_ROW_RST: begin
								row_q <= '0;
							end
							OP_TXN: begin
								if (head_cmd.last && (n_c == '0)) begin
									txn_q <= '0;
									row_q <= row_q + 1'b1;
								end else begin
									if (head_cmd.set_en) begin
										txn_q[head_cmd.id] <= 1'b1;
									end
									if (head_cmd.last) begin
										state_q    <= S_SCAN;
										rd_ptr_q   <= '0;
										rd_vld_s1  <= 1'b0;
										hold_vld_q <= 1'b0;
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD_WR: begin
					pat_valid_q[add_slot_q] <= 1'b1;
					state_q                 <= S_IDLE;
				end
				S_SCAN: begin
					if (adv_c) begin
						rd_vld_s1 <= rd_issue_c;
						if (rd_issue_c) begin
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end
						if (rd_vld_s1 && match_c) begin
							hold_vld_q <= 1'b1;
						end
					end
					if (finish_c) begin
						hold_vld_q <= 1'b0;
						txn_q      <= '0;
						row_q      <= row_q + 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_vld_q;
	assign row_index       = out_row_q;
	assign matched_pattern = out_pat_q;
	assign last_match      = out_last_q;

`ifndef SYNTH
	// Scan bookkeeping is only live while a scan runs.
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SCAN) |-> (!hold_vld_q && !rd_vld_s1))
		else $error("scan state left behind outside a scan");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_ptr_q <= n_c))
		else $error("scan pointer ran past the pattern count");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		finish_c |=> (row_q == ROW_W'($past(row_q) + 1'b1)) && (txn_q == '0))
		else $error("row counter or transaction bitmap wrong after a scan");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_WR) |=> (state_q == S_IDLE))
		else $error("pattern update took more than one write cycle");
`endif

endmodule
